### hdl/pfr_pkg.sv
`timescale 1ns / 1ps

package pfr_pkg;

  // Frame layout
  localparam int PAYLOAD_BYTES    = 40;
  localparam int PAGE_BYTES       = 26;
  localparam int FLAGS_BYTE_INDEX = 0;
  localparam int COMMON_BYTES     = (PAYLOAD_BYTES > PAGE_BYTES) ?
                                    (PAYLOAD_BYTES - PAGE_BYTES) : 0;

  // Header and trailer characters
  localparam logic [7:0] HDR_FIRST  = 8'h3E;  // '>'
  localparam logic [7:0] HDR_SECOND = 8'h2A;  // '*'
  localparam logic [7:0] TRAILER    = 8'h3C;  // '<'

  // Page codes from the flags byte
  localparam logic [1:0] PAGE_ONE = 2'd1;
  localparam logic [1:0] PAGE_TWO = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HDR2    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

endpackage

### hdl/paged_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Paged frame receiver: takes one received byte per transfer on rx_* and gives
// exactly one result per byte on res_* (a store write for payload bytes, a
// frame-end status for the trailer byte, neither for other bytes). A byte can
// be taken every clock cycle; its result appears in the result register in
// the cycle after the transfer. The input is stalled only while that single
// result register holds a result that the downstream side is stalling.
module paged_frame_receiver_unit
  import pfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       store_write,
  output logic [6:0] store_address,
  output logic [7:0] store_data,
  output logic       frame_end,
  output logic       frame_good,
  output logic [1:0] frame_page
);

  localparam logic [5:0] PAYLOAD_LEN = 6'(PAYLOAD_BYTES);
  localparam logic [5:0] COMMON_LEN  = 6'(COMMON_BYTES);
  localparam logic [5:0] FLAGS_IDX   = 6'(FLAGS_BYTE_INDEX);
  localparam logic [7:0] SHIFT_ONE   = 8'(PAGE_BYTES);
  localparam logic [7:0] SHIFT_TWO   = 8'(2 * PAGE_BYTES);

  phase_t     phase, phase_next;
  logic [5:0] bytes_left, bytes_left_next;
  logic [1:0] page_bits, page_bits_next;

  logic       accept;
  logic       wr_next, end_next, good_next;
  logic [6:0] addr_next;
  logic [7:0] data_next;
  logic [1:0] pg_next;

  logic [5:0] left, idx;
  logic [7:0] shift, addr_sum;

  assign rx_stall = res_valid && res_stall;
  assign accept   = rx_valid && !rx_stall;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bytes_left <= '0;
      page_bits  <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      page_bits  <= page_bits_next;
    end
  end

  // Payload index and store address
  always_comb begin
    if (bytes_left == '0 || bytes_left > PAYLOAD_LEN) begin
      left = 6'd1;
      idx  = '0;
    end else begin
      left = bytes_left;
      idx  = PAYLOAD_LEN - bytes_left;
    end
    case (page_bits)
      PAGE_ONE: shift = SHIFT_ONE;
      PAGE_TWO: shift = SHIFT_TWO;
      default:  shift = '0;
    endcase
    addr_sum = {2'b00, idx} + shift;
  end

  // Next state and result
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    page_bits_next  = page_bits;
    wr_next         = 1'b0;
    addr_next       = '0;
    data_next       = '0;
    end_next        = 1'b0;
    good_next       = 1'b0;
    pg_next         = '0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == HDR_FIRST) phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        if (rx_byte == HDR_SECOND) begin
          phase_next      = PH_PAYLOAD;
          bytes_left_next = PAYLOAD_LEN;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        wr_next   = 1'b1;
        data_next = rx_byte;
        if (idx < COMMON_LEN) begin
          if (idx == FLAGS_IDX) page_bits_next = rx_byte[1:0];
          addr_next = {1'b0, idx};
        end else begin
          addr_next = addr_sum[6:0];
        end
        bytes_left_next = left - 6'd1;
        if (left == 6'd1) phase_next = PH_TRAILER;
      end
      PH_TRAILER: begin
        end_next   = 1'b1;
        good_next  = (rx_byte == TRAILER);
        pg_next    = page_bits;
        phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_write   <= wr_next;
      store_address <= addr_next;
      store_data    <= data_next;
      frame_end     <= end_next;
      frame_good    <= good_next;
      frame_page    <= pg_next;
    end
  end

endmodule

### verif/paged_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module paged_frame_receiver_unit_tb;
  import pfr_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 950;
  localparam int TAIL_ITEMS   = 150;
  localparam int SETTLE_LEN   = 16;

  // One byte to send; drain holds it back until all results are in
  typedef struct {
    logic [7:0] b;
    bit         drain;
  } rx_item_t;

  typedef struct packed {
    logic       wr;
    logic [6:0] addr;
    logic [7:0] data;
    logic       fend;
    logic       good;
    logic [1:0] page;
  } store_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       store_write;
  logic [6:0] store_address;
  logic [7:0] store_data;
  logic       frame_end;
  logic       frame_good;
  logic [1:0] frame_page;

  rx_item_t      pending_bytes[$];
  store_result_t expected_results[$];
  int            total_items = 0;
  int            n_in = 0;
  int            n_out = 0;
  int            errors = 0;
  int            cycles = 0;

  // Receiver state mirror
  phase_t     rx_phase = PH_HUNT;
  logic [5:0] left_cnt = '0;
  logic [1:0] page_sel = '0;

  // Idle control
  int   tx_gap = 0;
  int   rs_hold = 0;
  logic tx_calm = 1'b0;
  logic rs_calm = 1'b0;
  logic tail_quiet = 1'b0;

  paged_frame_receiver_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .store_write   (store_write),
    .store_address (store_address),
    .store_data    (store_data),
    .frame_end     (frame_end),
    .frame_good    (frame_good),
    .frame_page    (frame_page)
  );

  always #6 clk = ~clk;

  // Advance the receiver mirror by one byte and return its result
  function automatic store_result_t receive_byte(logic [7:0] b);
    store_result_t r;
    int unsigned   left;
    int unsigned   idx;
    int unsigned   shift;
    r = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == HDR_FIRST) rx_phase = PH_HDR2;
      end
      PH_HDR2: begin
        // a bad second byte is not retried as a first byte
        if (b == HDR_SECOND) begin
          rx_phase = PH_PAYLOAD;
          left_cnt = 6'(PAYLOAD_BYTES);
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        left = 32'(left_cnt);
        if (left == 0 || left > PAYLOAD_BYTES) begin
          left = 1;
          idx = 0;
        end else begin
          idx = PAYLOAD_BYTES - left;
        end
        if (idx < COMMON_BYTES) begin
          if (idx == FLAGS_BYTE_INDEX) page_sel = b[1:0];
          r.addr = 7'(idx);
        end else begin
          // page 3 lands where page 0 does
          shift = (page_sel == PAGE_ONE) ? PAGE_BYTES :
                  (page_sel == PAGE_TWO) ? 2 * PAGE_BYTES : 0;
          r.addr = 7'(idx + shift);
        end
        r.wr = 1'b1;
        r.data = b;
        left = left - 1;
        left_cnt = 6'(left);
        if (left == 0) rx_phase = PH_TRAILER;
      end
      default: begin
        r.fend = 1'b1;
        r.good = (b == TRAILER);
        r.page = page_sel;
        rx_phase = PH_HUNT;
      end
    endcase
    return r;
  endfunction

  task automatic push_byte(logic [7:0] b, bit drain);
    rx_item_t it;
    it.b = b;
    it.drain = drain;
    pending_bytes.push_back(it);
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // Driver: one transfer per handshake, random idle bursts
  always @(posedge clk) begin
    bit       took;
    rx_item_t item;
    if (rst) begin
      rx_valid <= 1'b0;
      tx_gap <= 0;
      tx_calm <= 1'b0;
      tail_quiet <= 1'b0;
      rx_phase = PH_HUNT;
      left_cnt = '0;
      page_sel = '0;
    end else begin
      took = rx_valid && !rx_stall;
      if (took) begin
        expected_results.push_back(receive_byte(rx_byte));
        n_in <= n_in + 1;
      end
      if ($urandom_range(0, 49) == 0) tx_calm <= !tx_calm;
      tail_quiet <= (pending_bytes.size() < TAIL_ITEMS);
      if (!rx_valid || took) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          rx_valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          rx_valid <= 1'b0;
        end else if (pending_bytes[0].drain && (took || n_out < n_in)) begin
          // hold off until the result side has caught up
          rx_valid <= 1'b0;
        end else if (!tx_calm && !tail_quiet && $urandom_range(0, 5) == 0) begin
          tx_gap <= $urandom_range(0, 15);
          rx_valid <= 1'b0;
        end else begin
          item = pending_bytes.pop_front();
          rx_byte <= item.b;
          rx_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each result transfer, stall in random bursts
  always @(posedge clk) begin
    store_result_t want;
    if (rst) begin
      res_stall <= 1'b0;
      rs_hold <= 0;
      rs_calm <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        n_out <= n_out + 1;
        if (expected_results.size() == 0) begin
          $error("result with no byte pending: address %0d, data %0d",
                 store_address, store_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("store_write", 8'(want.wr), 8'(store_write));
          check_field("store_address", 8'(want.addr), 8'(store_address));
          check_field("store_data", want.data, store_data);
          check_field("frame_end", 8'(want.fend), 8'(frame_end));
          check_field("frame_good", 8'(want.good), 8'(frame_good));
          check_field("frame_page", 8'(want.page), 8'(frame_page));
        end
      end
      if ($urandom_range(0, 49) == 0) rs_calm <= !rs_calm;
      if (rs_hold > 0) begin
        rs_hold <= rs_hold - 1;
        res_stall <= 1'b1;
      end else if (!rs_calm && !tail_quiet && $urandom_range(0, 6) == 0) begin
        rs_hold <= $urandom_range(0, 15);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("paged_frame_receiver_unit regression: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int k;
    int n;
    int frame_no;
    int pick;

    // Header hunting: stray bytes, bad second byte not rechecked as '>'
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(HDR_SECOND, 1'b0);
    push_byte(TRAILER, 1'b0);
    push_byte(HDR_FIRST, 1'b0);
    push_byte(HDR_FIRST, 1'b0);
    push_byte(HDR_SECOND, 1'b0);
    push_byte(HDR_FIRST, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(HDR_FIRST, 1'b0);
    push_byte(HDR_FIRST, 1'b0);
    push_byte(HDR_FIRST, 1'b0);
    push_byte(HDR_SECOND, 1'b0);
    // Frame on page 3 with extreme payload values and a good trailer
    push_byte(8'hFF, 1'b0);
    for (k = 1; k < PAYLOAD_BYTES; k++) push_byte(k[0] ? 8'h00 : 8'hFF, 1'b0);
    push_byte(TRAILER, 1'b0);

    // Mostly well-formed frames, some broken headers and noise
    frame_no = 0;
    while (pending_bytes.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        push_byte(HDR_FIRST, (frame_no % 8) == 3);
        push_byte(HDR_SECOND, 1'b0);
        push_byte(8'($urandom), 1'b0);
        for (k = 1; k < PAYLOAD_BYTES; k++) begin
          if ($urandom_range(0, 7) == 0)
            push_byte($urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b0);
          else
            push_byte(8'($urandom), 1'b0);
        end
        push_byte(($urandom_range(0, 9) < 7) ? TRAILER : 8'($urandom), 1'b0);
        frame_no++;
      end else if (pick == 8) begin
        push_byte(HDR_FIRST, 1'b0);
        push_byte($urandom_range(0, 1) ? HDR_FIRST : 8'($urandom), 1'b0);
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) push_byte(8'($urandom), 1'b0);
      end
    end
    total_items = pending_bytes.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (n_in < total_items || n_out < n_in) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("paged_frame_receiver_unit regression: pass");
    end else begin
      $display("paged_frame_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule
